>>> rtl/assert_macros.svh
// Assertion macros shared by the rotate unit modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// A consequence that holds in the same cycle as its cause.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// A consequence that holds in the cycle after its cause.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/sp2p_pkg.sv
// Types and constants of the semi-planar to planar rotate unit.
`default_nettype none

package sp2p_pkg;

   // Payload of one request and of one result.
   typedef struct packed {
      logic       is_chroma;
      logic       frame_start;
      logic [7:0] data_byte;
   } req_type;

   localparam int ADDR_W = 23;

   typedef struct packed {
      logic [ADDR_W-1:0] dest_address;
      logic [7:0]        pixel_value;
   } rsp_type;

   // Rotation codes.
   typedef enum logic [1:0] {
      ROT_NONE  = 2'd0,
      ROT_CW90  = 2'd1,
      ROT_180   = 2'd2,
      ROT_CCW90 = 2'd3
   } rot_mode_type;

   // Register indexes of the control port.
   typedef enum logic [2:0] {
      REG_OUT_WIDTH        = 3'd0,
      REG_OUT_HEIGHT       = 3'd1,
      REG_ROTATION_MODE    = 3'd2,
      REG_EVEN_BYTE_IS_U   = 3'd3,
      REG_LUMA_ROW_BYTES   = 3'd4,
      REG_CHROMA_ROW_BYTES = 3'd5
   } csr_index_type;

   localparam int CSR_ADDR_W = 5;

   // Register reset values.
   localparam logic [11:0] OUT_WIDTH_RESET        = 12'd640;
   localparam logic [11:0] OUT_HEIGHT_RESET       = 12'd480;
   localparam logic [12:0] LUMA_ROW_BYTES_RESET   = 13'd640;
   localparam logic [12:0] CHROMA_ROW_BYTES_RESET = 13'd640;

   // Row counters saturate at these values.
   localparam int          LUMA_ROW_W     = 12;
   localparam int          CHROMA_ROW_W   = 11;
   localparam logic [11:0] LUMA_ROW_MAX   = 12'd4095;
   localparam logic [10:0] CHROMA_ROW_MAX = 11'd2047;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

endpackage

`default_nettype wire

>>> rtl/sp2p_front.sv
// Front end: plane position counters and classification of each request.
`default_nettype none

`include "assert_macros.svh"

module sp2p_front #(
   parameter int MAX_ROW_BYTES = 4096,
   parameter int DIM_W         = 12
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_push,
   input  wire sp2p_pkg::req_type   in_item,
   input  wire                      queue_full,
   input  wire [DIM_W-1:0]          width,
   input  wire [DIM_W-1:0]          height,
   input  wire sp2p_pkg::rot_mode_type mode,
   input  wire                      even_byte_is_u,
   input  wire [12:0]               luma_row_bytes,
   input  wire [12:0]               chroma_row_bytes,
   output logic                     work_valid,
   output logic                     work_is_chroma,
   output logic                     work_to_u,
   output logic [DIM_W-1:0]         work_row,
   output logic [DIM_W-1:0]         work_col,
   output logic [7:0]               work_data
);

   localparam int COL_W   = $clog2(MAX_ROW_BYTES);
   localparam int PITCH_W = $clog2(MAX_ROW_BYTES + 1);

   logic [COL_W-1:0]                  luma_col_ff, luma_col_in, luma_col_cur;
   logic [sp2p_pkg::LUMA_ROW_W-1:0]   luma_row_ff, luma_row_in, luma_row_cur;
   logic [COL_W-1:0]                  chroma_col_ff, chroma_col_in, chroma_col_cur;
   logic [sp2p_pkg::CHROMA_ROW_W-1:0] chroma_row_ff, chroma_row_in, chroma_row_cur;

   logic               accept;
   logic               rotated;
   logic [DIM_W-1:0]   luma_cols, luma_rows, chroma_pairs, chroma_rows;
   logic [PITCH_W-1:0] luma_pitch, chroma_pitch;
   logic               luma_keep, chroma_keep;
   logic               luma_wrap, chroma_wrap;

   assign accept = in_push && !queue_full;

   // Effective pitches: zero counts as one, large values are clamped.
   always_comb begin
      if (luma_row_bytes == '0) begin
         luma_pitch = PITCH_W'(1);
      end else if (32'(luma_row_bytes) > 32'(MAX_ROW_BYTES)) begin
         luma_pitch = PITCH_W'(MAX_ROW_BYTES);
      end else begin
         luma_pitch = PITCH_W'(luma_row_bytes);
      end
      if (chroma_row_bytes == '0) begin
         chroma_pitch = PITCH_W'(1);
      end else if (32'(chroma_row_bytes) > 32'(MAX_ROW_BYTES)) begin
         chroma_pitch = PITCH_W'(MAX_ROW_BYTES);
      end else begin
         chroma_pitch = PITCH_W'(chroma_row_bytes);
      end
   end

   // Source geometry of both planes and the keep decision.
   always_comb begin
      luma_col_cur   = in_item.frame_start ? '0 : luma_col_ff;
      luma_row_cur   = in_item.frame_start ? '0 : luma_row_ff;
      chroma_col_cur = in_item.frame_start ? '0 : chroma_col_ff;
      chroma_row_cur = in_item.frame_start ? '0 : chroma_row_ff;

      rotated      = (mode == sp2p_pkg::ROT_CW90) || (mode == sp2p_pkg::ROT_CCW90);
      luma_cols    = rotated ? height : width;
      luma_rows    = rotated ? width : height;
      chroma_pairs = rotated ? (height >> 1) : (width >> 1);
      chroma_rows  = rotated ? (width >> 1) : (height >> 1);

      luma_keep   = (32'(luma_col_cur) < 32'(luma_cols)) &&
                    (32'(luma_row_cur) < 32'(luma_rows));
      chroma_keep = (32'(chroma_col_cur >> 1) < 32'(chroma_pairs)) &&
                    (32'(chroma_row_cur) < 32'(chroma_rows));

      luma_wrap   = (32'(luma_col_cur) + 32'd1) >= 32'(luma_pitch);
      chroma_wrap = (32'(chroma_col_cur) + 32'd1) >= 32'(chroma_pitch);
   end

   // Counter advance for the plane of the request; the row saturates.
   always_comb begin
      luma_col_in   = luma_col_cur;
      luma_row_in   = luma_row_cur;
      chroma_col_in = chroma_col_cur;
      chroma_row_in = chroma_row_cur;
      if (!in_item.is_chroma) begin
         if (luma_wrap) begin
            luma_col_in = '0;
            if (luma_row_cur != sp2p_pkg::LUMA_ROW_MAX) begin
               luma_row_in = luma_row_cur + 1'b1;
            end
         end else begin
            luma_col_in = luma_col_cur + 1'b1;
         end
      end else begin
         if (chroma_wrap) begin
            chroma_col_in = '0;
            if (chroma_row_cur != sp2p_pkg::CHROMA_ROW_MAX) begin
               chroma_row_in = chroma_row_cur + 1'b1;
            end
         end else begin
            chroma_col_in = chroma_col_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_col_ff   <= '0;
         luma_row_ff   <= '0;
         chroma_col_ff <= '0;
         chroma_row_ff <= '0;
      end else if (accept) begin
         luma_col_ff   <= luma_col_in;
         luma_row_ff   <= luma_row_in;
         chroma_col_ff <= chroma_col_in;
         chroma_row_ff <= chroma_row_in;
      end
   end

   // Work entry for the back end: source position within the plane.
   always_comb begin
      work_valid     = accept && (in_item.is_chroma ? chroma_keep : luma_keep);
      work_is_chroma = in_item.is_chroma;
      work_to_u      = (!chroma_col_cur[0]) == even_byte_is_u;
      work_row       = in_item.is_chroma ? DIM_W'(chroma_row_cur) : DIM_W'(luma_row_cur);
      work_col       = in_item.is_chroma ? DIM_W'(chroma_col_cur >> 1)
                                         : DIM_W'(luma_col_cur);
      work_data      = in_item.data_byte;
   end

   `ASSERT_IMPLY(a_no_push_when_full, clock, reset, work_valid, !queue_full)
   `ASSERT_NEXT(a_frame_clears_chroma, clock, reset,
      accept && in_item.frame_start && !in_item.is_chroma,
      chroma_col_ff == '0 && chroma_row_ff == '0)

endmodule

`default_nettype wire

>>> rtl/sp2p_queue.sv
// Short queue of work entries between the front and back ends.
`default_nettype none

`include "assert_macros.svh"

module sp2p_queue #(
   parameter int WIDTH = 34
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   input  wire              pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]                 slot_ff [sp2p_pkg::QUEUE_DEPTH];
   logic [sp2p_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sp2p_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sp2p_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == sp2p_pkg::QUEUE_CNT_W'(sp2p_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   `ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= sp2p_pkg::QUEUE_CNT_W'(sp2p_pkg::QUEUE_DEPTH))
   `ASSERT_NEXT(a_count_grows, clock, reset, push && !pop,
      count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/sp2p_back.sv
// Back end: rotated planar address generation in two pipeline stages.
`default_nettype none

`include "assert_macros.svh"

module sp2p_back #(
   parameter int DIM_W = 12
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         work_valid,
   input  wire                         work_is_chroma,
   input  wire                         work_to_u,
   input  wire [DIM_W-1:0]             work_row,
   input  wire [DIM_W-1:0]             work_col,
   input  wire [7:0]                   work_data,
   output logic                        work_pop,
   input  wire [DIM_W-1:0]             width,
   input  wire [DIM_W-1:0]             height,
   input  wire sp2p_pkg::rot_mode_type mode,
   output logic                        rsp_empty,
   input  wire                         rsp_pop,
   output sp2p_pkg::rsp_type           rsp_data
);

   localparam int AW = sp2p_pkg::ADDR_W;

   logic [AW-1:0] luma_size_ff, chroma_size_ff;

   logic [DIM_W-1:0]   half_w, half_h, pw, ph, dest_row, dest_col;
   logic [2*DIM_W-1:0] prod_full;
   logic [2*DIM_W-1:0] luma_prod, chroma_prod;
   logic [AW-1:0]      offset;

   logic          s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_prod_ff, s1_off_ff;
   logic [7:0]    s1_data_ff;
   logic          s2_valid_ff, s2_valid_in;
   logic [AW-1:0] s2_addr_ff;
   logic [7:0]    s2_data_ff;
   logic          s1_ready, s2_ready;

   assign half_w = width >> 1;
   assign half_h = height >> 1;

   // Full-width plane size products.
   assign luma_prod   = width * height;
   assign chroma_prod = half_w * half_h;

   // Plane sizes, used to form the U and V plane bases.
   always_ff @(posedge clock) begin
      luma_size_ff   <= AW'(luma_prod);
      chroma_size_ff <= AW'(chroma_prod);
   end

   // Destination row and column of the entry at the queue head.
   always_comb begin
      pw = work_is_chroma ? half_w : width;
      ph = work_is_chroma ? half_h : height;
      case (mode)
         sp2p_pkg::ROT_CW90: begin
            dest_row = work_col;
            dest_col = pw - 1'b1 - work_row;
         end
         sp2p_pkg::ROT_180: begin
            dest_row = ph - 1'b1 - work_row;
            dest_col = pw - 1'b1 - work_col;
         end
         sp2p_pkg::ROT_CCW90: begin
            dest_row = ph - 1'b1 - work_col;
            dest_col = work_row;
         end
         default: begin
            dest_row = work_row;
            dest_col = work_col;
         end
      endcase
      prod_full = dest_row * pw;
      offset    = AW'(dest_col)
                + (work_is_chroma ? luma_size_ff : '0)
                + ((work_is_chroma && !work_to_u) ? chroma_size_ff : '0);
   end

   // Stage handshakes.
   assign s2_ready = !s2_valid_ff || rsp_pop;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign work_pop = work_valid && s1_ready;

   assign s1_valid_in = s1_ready ? work_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage one holds the product and the offset, stage two the address.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_prod_ff <= AW'(prod_full);
         s1_off_ff  <= offset;
         s1_data_ff <= work_data;
      end
      if (s2_ready) begin
         s2_addr_ff <= s1_prod_ff + s1_off_ff;
         s2_data_ff <= s1_data_ff;
      end
   end

   assign rsp_empty             = !s2_valid_ff;
   assign rsp_data.dest_address = s2_addr_ff;
   assign rsp_data.pixel_value  = s2_data_ff;

   `ASSERT_NEXT(a_stage1_holds, clock, reset, s1_valid_ff && !s2_ready,
      s1_valid_ff && $stable(s1_prod_ff) && $stable(s1_off_ff))

endmodule

`default_nettype wire

>>> rtl/semiplanar_to_planar_rotate_unit.sv
// A request accepted at the front passes through the queue, the stage one
// register and the stage two register before its result can be popped.
// Throughput: one request per clock while the queue is not full and results are
// popped, set by the front counter update and the two-stage address pipeline (one 12x12 multiply, then one add).
// Requests outside the used area advance the counters and give no result.
// Reset is synchronous and active high; it restores the register defaults
// and clears counters, queue and pipeline. No clearing pass is needed.
`default_nettype none

module semiplanar_to_planar_rotate_unit #(
   parameter int MAX_DIM       = 2048,
   parameter int MAX_ROW_BYTES = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_push,
   output logic                               req_full,
   input  wire sp2p_pkg::req_type             req_data,
   output logic                               rsp_empty,
   input  wire                                rsp_pop,
   output sp2p_pkg::rsp_type                  rsp_data,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [sp2p_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [31:0]                         csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int WORK_W = 2 + 2 * DIM_W + 8;

   logic [11:0]            out_width_ff, out_height_ff;
   sp2p_pkg::rot_mode_type rotation_mode_ff;
   logic                   even_byte_is_u_ff;
   logic [12:0]            luma_row_bytes_ff, chroma_row_bytes_ff;

   sp2p_pkg::csr_index_type csr_index;
   logic                    csr_write;
   logic [DIM_W-1:0]        width_eff, height_eff;

   logic              work_valid, work_is_chroma, work_to_u;
   logic [DIM_W-1:0]  work_row, work_col;
   logic [7:0]        work_data;
   logic [WORK_W-1:0] push_vec, head_vec;
   logic              queue_full, queue_empty, queue_pop;

   logic              head_is_chroma, head_to_u;
   logic [DIM_W-1:0]  head_row, head_col;
   logic [7:0]        head_data;

   // Control register port.
   assign csr_pready = 1'b1;
   assign csr_index  = sp2p_pkg::csr_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff        <= sp2p_pkg::OUT_WIDTH_RESET;
         out_height_ff       <= sp2p_pkg::OUT_HEIGHT_RESET;
         rotation_mode_ff    <= sp2p_pkg::ROT_NONE;
         even_byte_is_u_ff   <= 1'b1;
         luma_row_bytes_ff   <= sp2p_pkg::LUMA_ROW_BYTES_RESET;
         chroma_row_bytes_ff <= sp2p_pkg::CHROMA_ROW_BYTES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            sp2p_pkg::REG_OUT_WIDTH:        out_width_ff <= csr_pwdata[11:0];
            sp2p_pkg::REG_OUT_HEIGHT:       out_height_ff <= csr_pwdata[11:0];
            sp2p_pkg::REG_ROTATION_MODE:
               rotation_mode_ff <= sp2p_pkg::rot_mode_type'(csr_pwdata[1:0]);
            sp2p_pkg::REG_EVEN_BYTE_IS_U:   even_byte_is_u_ff <= csr_pwdata[0];
            sp2p_pkg::REG_LUMA_ROW_BYTES:   luma_row_bytes_ff <= csr_pwdata[12:0];
            sp2p_pkg::REG_CHROMA_ROW_BYTES: chroma_row_bytes_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         sp2p_pkg::REG_OUT_WIDTH:        csr_prdata = 32'(out_width_ff);
         sp2p_pkg::REG_OUT_HEIGHT:       csr_prdata = 32'(out_height_ff);
         sp2p_pkg::REG_ROTATION_MODE:    csr_prdata = 32'(rotation_mode_ff);
         sp2p_pkg::REG_EVEN_BYTE_IS_U:   csr_prdata = 32'(even_byte_is_u_ff);
         sp2p_pkg::REG_LUMA_ROW_BYTES:   csr_prdata = 32'(luma_row_bytes_ff);
         sp2p_pkg::REG_CHROMA_ROW_BYTES: csr_prdata = 32'(chroma_row_bytes_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   // Destination dimensions clamped to the supported maximum.
   assign width_eff  = (32'(out_width_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                          : DIM_W'(out_width_ff);
   assign height_eff = (32'(out_height_ff) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : DIM_W'(out_height_ff);

   assign req_full = queue_full;

   sp2p_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .DIM_W         (DIM_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .in_push          (req_push),
      .in_item          (req_data),
      .queue_full       (queue_full),
      .width            (width_eff),
      .height           (height_eff),
      .mode             (rotation_mode_ff),
      .even_byte_is_u   (even_byte_is_u_ff),
      .luma_row_bytes   (luma_row_bytes_ff),
      .chroma_row_bytes (chroma_row_bytes_ff),
      .work_valid       (work_valid),
      .work_is_chroma   (work_is_chroma),
      .work_to_u        (work_to_u),
      .work_row         (work_row),
      .work_col         (work_col),
      .work_data        (work_data)
   );

   assign push_vec = {work_is_chroma, work_to_u, work_row, work_col, work_data};

   sp2p_queue #(
      .WIDTH (WORK_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_valid),
      .push_data (push_vec),
      .pop       (queue_pop),
      .head_data (head_vec),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign {head_is_chroma, head_to_u, head_row, head_col, head_data} = head_vec;

   sp2p_back #(
      .DIM_W (DIM_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .work_valid     (!queue_empty),
      .work_is_chroma (head_is_chroma),
      .work_to_u      (head_to_u),
      .work_row       (head_row),
      .work_col       (head_col),
      .work_data      (head_data),
      .work_pop       (queue_pop),
      .width          (width_eff),
      .height         (height_eff),
      .mode           (rotation_mode_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire
